// ===== sv/kmp_stream_matcher_defines.svh =====
// Assertion macros used by the top-level matcher RTL.
// The bodies sample on clk and are switched off while arst_n is low.
`ifndef KMP_STREAM_MATCHER_DEFINES_SVH
`define KMP_STREAM_MATCHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KMP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/kmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

	// Pattern capacity and text position width.
	localparam int MAX_PATTERN   = 128;
	localparam int POSITION_BITS = 16;

	// Index into the pattern stores, and a length that can reach the capacity.
	localparam int PAT_AW = $clog2(MAX_PATTERN);
	localparam int PLEN_W = $clog2(MAX_PATTERN + 1);

	// Width of the match start arithmetic: wide enough for index + 1 and the length.
	localparam int SUM_W = ((PLEN_W > POSITION_BITS) ? PLEN_W : POSITION_BITS) + 1;

	localparam logic [PLEN_W-1:0]        MAX_LEN = PLEN_W'(MAX_PATTERN);
	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	// Item kinds.
	localparam logic KIND_PATTERN = 1'b0;
	localparam logic KIND_TEXT    = 1'b1;

	// One input request.
	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic       first;
		logic       last;
	} item_t;

	// One result.
	typedef struct packed {
		logic                     match;
		logic [POSITION_BITS-1:0] match_position;
		logic                     none_found;
		logic                     pattern_overflow;
		logic                     position_overflow;
	} result_t;

	// Access to the pattern and prefix stores.
	typedef struct packed {
		logic              store_we;
		logic [PAT_AW-1:0] store_waddr;
		logic [7:0]        store_wdata;
		logic [PAT_AW-1:0] store_raddr;
		logic              tbl_we;
		logic [PAT_AW-1:0] tbl_waddr;
		logic [PAT_AW-1:0] tbl_wdata;
		logic [PAT_AW-1:0] tbl_raddr;
	} mem_req_t;

	// Registered read data from the stores.
	typedef struct packed {
		logic [7:0]        store_rdata;
		logic [PAT_AW-1:0] tbl_rdata;
	} mem_rsp_t;

endpackage

`default_nettype wire

// ===== sv/kmp_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kmp_store (
	input  wire logic              clk,
	input  wire kmp_pkg::mem_req_t mem_req,
	output kmp_pkg::mem_rsp_t      mem_rsp
);

	logic [7:0]                store_mem [kmp_pkg::MAX_PATTERN];
	logic [kmp_pkg::PAT_AW-1:0] tbl_mem   [kmp_pkg::MAX_PATTERN];
	logic [7:0]                store_rdata_q;
	logic [kmp_pkg::PAT_AW-1:0] tbl_rdata_q;

	// Pattern characters: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_req.store_we) begin
			store_mem[mem_req.store_waddr] <= mem_req.store_wdata;
		end
		store_rdata_q <= store_mem[mem_req.store_raddr];
	end

	// Longest proper prefix-suffix lengths: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_req.tbl_we) begin
			tbl_mem[mem_req.tbl_waddr] <= mem_req.tbl_wdata;
		end
		tbl_rdata_q <= tbl_mem[mem_req.tbl_raddr];
	end

	assign mem_rsp.store_rdata = store_rdata_q;
	assign mem_rsp.tbl_rdata   = tbl_rdata_q;

endmodule

`default_nettype wire

// ===== sv/kmp_walk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kmp_walk (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire kmp_pkg::item_t    item,
	output logic                   item_ready,
	output logic                   res_valid,
	output kmp_pkg::result_t       res,
	input  wire logic              res_ready,
	output kmp_pkg::mem_req_t      mem_req,
	input  wire kmp_pkg::mem_rsp_t mem_rsp
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_TAIL = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]                        state_q;
	logic [kmp_pkg::PLEN_W-1:0]        plen_q;
	logic [kmp_pkg::PAT_AW-1:0]        bpl_q;
	logic [kmp_pkg::PAT_AW-1:0]        matched_q;
	logic [kmp_pkg::POSITION_BITS-1:0] ti_q;
	logic                              found_q;

	logic                       kind_q;
	logic [7:0]                 c_q;
	logic                       last_q;
	logic [kmp_pkg::PAT_AW-1:0] len_q;
	kmp_pkg::result_t           res_q;

	logic                              accept;
	logic [kmp_pkg::PLEN_W-1:0]        plen_eff;
	logic [kmp_pkg::POSITION_BITS-1:0] ti_eff;
	logic [kmp_pkg::PAT_AW-1:0]        matched_eff;
	logic                              found_eff;
	logic                              eq;
	logic                              stop;
	logic [kmp_pkg::PLEN_W-1:0]        len_next;
	logic [kmp_pkg::PLEN_W-1:0]        plen_m1;
	logic [kmp_pkg::SUM_W-1:0]         tip1;
	logic [kmp_pkg::SUM_W-1:0]         plen_x;
	logic [kmp_pkg::SUM_W-1:0]         diff;
	logic [kmp_pkg::POSITION_BITS-1:0] start_pos;
	kmp_pkg::result_t                  res_init;
	kmp_pkg::result_t                  res_hit;

	// Shared compare unit and the values that a new request starts from.
	always_comb begin
		accept      = (state_q == ST_IDLE) && item_valid;
		plen_eff    = item.first ? '0 : plen_q;
		ti_eff      = item.first ? '0 : ti_q;
		matched_eff = item.first ? '0 : matched_q;
		found_eff   = item.first ? 1'b0 : found_q;
		eq          = (mem_rsp.store_rdata == c_q);
		stop        = (len_q == '0) || eq;
		len_next    = kmp_pkg::PLEN_W'(len_q) + kmp_pkg::PLEN_W'(eq);
		plen_m1     = plen_q - kmp_pkg::PLEN_W'(1);
		tip1        = kmp_pkg::SUM_W'(ti_q) + kmp_pkg::SUM_W'(1);
		plen_x      = kmp_pkg::SUM_W'(plen_q);
		diff        = tip1 - plen_x;
		start_pos   = (tip1 >= plen_x) ? diff[kmp_pkg::POSITION_BITS-1:0] : '0;
		// Result flags known at acceptance, and the result once a match completes.
		res_init = '0;
		if (item.kind == kmp_pkg::KIND_PATTERN) begin
			res_init.pattern_overflow  = (plen_eff == kmp_pkg::MAX_LEN);
			res_init.position_overflow = (ti_q == kmp_pkg::POS_MAX);
		end else begin
			res_init.position_overflow = (ti_eff == kmp_pkg::POS_MAX);
		end
		res_hit                = res_q;
		res_hit.match          = 1'b1;
		res_hit.match_position = start_pos;
	end

	// Store addressing: the character goes in on acceptance, its prefix length
	// once the fallback walk settles (on acceptance for the first character).
	always_comb begin
		mem_req             = '0;
		mem_req.store_we    = accept && (item.kind == kmp_pkg::KIND_PATTERN) &&
			(plen_eff != kmp_pkg::MAX_LEN);
		mem_req.store_waddr = plen_eff[kmp_pkg::PAT_AW-1:0];
		mem_req.store_wdata = item.data_byte;
		mem_req.store_raddr = len_q;
		if (accept && (item.kind == kmp_pkg::KIND_PATTERN) && (plen_eff == '0)) begin
			mem_req.tbl_we    = 1'b1;
			mem_req.tbl_waddr = '0;
			mem_req.tbl_wdata = '0;
		end else if ((state_q == ST_CMP) && (kind_q == kmp_pkg::KIND_PATTERN) && stop) begin
			mem_req.tbl_we    = 1'b1;
			mem_req.tbl_waddr = plen_q[kmp_pkg::PAT_AW-1:0];
			mem_req.tbl_wdata = len_next[kmp_pkg::PAT_AW-1:0];
		end
		// During the compare, fetch the entry for the full pattern in case of a match.
		mem_req.tbl_raddr = (state_q == ST_CMP) ? plen_m1[kmp_pkg::PAT_AW-1:0] :
			len_q - kmp_pkg::PAT_AW'(1);
	end

	// Sequencer and matcher state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			plen_q    <= '0;
			bpl_q     <= '0;
			matched_q <= '0;
			ti_q      <= '0;
			found_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (item.kind == kmp_pkg::KIND_PATTERN) begin
							if (item.first) begin
								matched_q <= '0;
							end
							if (plen_eff == kmp_pkg::MAX_LEN) begin
								state_q <= ST_DONE;
							end else if (plen_eff == '0) begin
								bpl_q   <= '0;
								plen_q  <= kmp_pkg::PLEN_W'(1);
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_READ;
							end
						end else begin
							ti_q      <= ti_eff;
							found_q   <= found_eff;
							matched_q <= matched_eff;
							state_q   <= (plen_q == '0) ? ST_DONE : ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!stop) begin
						state_q <= ST_READ;
					end else if (kind_q == kmp_pkg::KIND_PATTERN) begin
						bpl_q   <= len_next[kmp_pkg::PAT_AW-1:0];
						plen_q  <= plen_q + kmp_pkg::PLEN_W'(1);
						state_q <= ST_DONE;
					end else if (len_next == plen_q) begin
						found_q <= 1'b1;
						state_q <= ST_TAIL;
					end else begin
						matched_q <= len_next[kmp_pkg::PAT_AW-1:0];
						state_q   <= ST_DONE;
					end
				end
				ST_TAIL: begin
					matched_q <= mem_rsp.tbl_rdata;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						if ((kind_q == kmp_pkg::KIND_TEXT) && (ti_q != kmp_pkg::POS_MAX)) begin
							ti_q <= ti_q + kmp_pkg::POSITION_BITS'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request payload, walk length and the result being assembled.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= item.kind;
			c_q    <= item.data_byte;
			last_q <= item.last;
			res_q  <= res_init;
			if (item.kind == kmp_pkg::KIND_PATTERN) begin
				len_q <= bpl_q;
			end else begin
				len_q <= (kmp_pkg::PLEN_W'(matched_eff) >= plen_q) ? '0 : matched_eff;
			end
		end else if ((state_q == ST_CMP) && !stop) begin
			len_q <= mem_rsp.tbl_rdata;
		end else if ((state_q == ST_CMP) && (kind_q == kmp_pkg::KIND_TEXT) &&
			(len_next == plen_q)) begin
			res_q <= res_hit;
		end
	end

	// The not-found report reads the flag as it stands once the walk is over.
	always_comb begin
		res            = res_q;
		res.none_found = (kind_q == kmp_pkg::KIND_TEXT) && last_q && !found_q;
	end

	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = (state_q == ST_DONE);

endmodule

`default_nettype wire

// ===== sv/kmp_stream_matcher.sv =====
// Streaming Knuth-Morris-Pratt matcher.
// Requests arrive on item_valid/item_ready; each carries kind, data_byte,
// first and last. Pattern requests (kind 0) append a character and extend the
// prefix-suffix table; first starts a new pattern. Text requests (kind 1) run
// the failure walk and give the start index of every occurrence that ends on
// them, overlapping ones included; first restarts the text index.
// Every request gives exactly one result on result_valid/result_ready.
// Each compare step of the walk passes through a read state and a compare
// state, since it waits on the registered read ports of the pattern and
// prefix stores; a request that completes a match also passes through a tail
// state. The walk then holds its result until the output register takes it,
// and only after that is a new request accepted. Requests that need no
// compare (first pattern character, pattern full, or text with no pattern
// loaded) go straight from acceptance to the result.
// The result sits in an output register, so a stalled receiver does not
// block the next request until the matcher has a further result to hand over.
// Reset clears the pattern length, partial match length, text index and
// found flag; the stores are not cleared and only written entries are used.
`timescale 1ns / 1ps
`default_nettype none
`include "kmp_stream_matcher_defines.svh"

module kmp_stream_matcher (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire kmp_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output kmp_pkg::result_t      result
);

	kmp_pkg::mem_req_t mem_req;
	kmp_pkg::mem_rsp_t mem_rsp;
	kmp_pkg::result_t  res;
	logic              res_valid;
	logic              res_ready;
	logic              result_valid_q;
	kmp_pkg::result_t  result_q;

	kmp_store u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.mem_rsp (mem_rsp)
	);

	kmp_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (res_ready),
		.mem_req    (mem_req),
		.mem_rsp    (mem_rsp)
	);

	// Output register: takes a new result whenever it is empty or being drained.
	assign res_ready = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_ready) begin
			result_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Accepting a request takes the matcher out of idle, so it is not ready again straight after.
	`KMP_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready,
		"matcher ready again straight after accepting a request")

	// A text byte that completes a match can never report that nothing matched.
	`KMP_ASSERT_SAME(a_match_not_none, result_valid && result.match, !result.none_found,
		"match and none_found raised together")

	// A dropped pattern byte is never a text result.
	`KMP_ASSERT_SAME(a_overflow_no_match, result_valid && result.pattern_overflow,
		!result.match && !result.none_found,
		"pattern overflow flagged on a text result")

endmodule

`default_nettype wire

// ===== test/kmp_stream_matcher_test.sv =====
`timescale 1ns / 1ps

module kmp_stream_matcher_test;
	import kmp_pkg::*;

	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int TEXT_RUN     = 40;

	// Tracks the matcher state and the results owed for accepted requests.
	class kmp_result_tracker;
		logic [7:0]               pat_chars [MAX_PATTERN];
		logic [PAT_AW-1:0]        border_len [MAX_PATTERN];
		logic [PLEN_W-1:0]        pat_len;
		logic [PLEN_W-1:0]        build_len;
		logic [PLEN_W-1:0]        partial_len;
		logic [POSITION_BITS-1:0] text_pos;
		logic                     seen_match;
		result_t                  pending_results[$];
		int                       errors;

		function new();
			foreach (pat_chars[i]) begin
				pat_chars[i] = '0;
				border_len[i] = '0;
			end
			pat_len = '0;
			build_len = '0;
			partial_len = '0;
			text_pos = '0;
			seen_match = 1'b0;
			errors = 0;
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		// Follows the failure links until the character fits or nothing is left.
		function logic [PLEN_W-1:0] fall_back(logic [PLEN_W-1:0] len, logic [7:0] c);
			while (len != 0 && len < MAX_LEN && pat_chars[len[PAT_AW-1:0]] != c)
				len = PLEN_W'(border_len[len[PAT_AW-1:0] - 1'b1]);
			return len;
		endfunction

		// Works out the result of one accepted request and queues it.
		function void note_request(item_t req);
			result_t                exp;
			logic [PLEN_W-1:0]      len;
			logic [POSITION_BITS:0] end_pos;

			exp = '0;
			if (req.kind == KIND_PATTERN) begin
				if (req.first) begin
					pat_len = '0;
					build_len = '0;
					partial_len = '0;
				end
				if (pat_len >= MAX_LEN) begin
					exp.pattern_overflow = 1'b1;
				end else begin
					pat_chars[pat_len[PAT_AW-1:0]] = req.data_byte;
					if (pat_len == 0) begin
						border_len[0] = '0;
						build_len = '0;
					end else begin
						len = fall_back(build_len, req.data_byte);
						if (len < pat_len && pat_chars[len[PAT_AW-1:0]] == req.data_byte)
							len = len + 1'b1;
						build_len = len;
						border_len[pat_len[PAT_AW-1:0]] = len[PAT_AW-1:0];
					end
					pat_len = pat_len + 1'b1;
				end
				exp.position_overflow = (text_pos == POS_MAX);
			end else begin
				if (req.first) begin
					text_pos = '0;
					partial_len = '0;
					seen_match = 1'b0;
				end
				exp.position_overflow = (text_pos == POS_MAX);
				if (pat_len != 0) begin
					len = partial_len;
					if (len >= pat_len)
						len = '0;
					len = fall_back(len, req.data_byte);
					if (len < pat_len && pat_chars[len[PAT_AW-1:0]] == req.data_byte)
						len = len + 1'b1;
					if (len == pat_len) begin
						exp.match = 1'b1;
						seen_match = 1'b1;
						end_pos = {1'b0, text_pos} + 1'b1;
						// Before enough bytes have passed, the start is floored at zero.
						if (end_pos >= pat_len)
							exp.match_position = POSITION_BITS'(end_pos - pat_len);
						len = PLEN_W'(border_len[PAT_AW'(pat_len - 1'b1)]);
					end
					partial_len = len;
				end
				if (text_pos != POS_MAX)
					text_pos = text_pos + 1'b1;
				if (req.last)
					exp.none_found = !seen_match;
			end
			pending_results.push_back(exp);
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 40)
				$display("MISMATCH at %0t ns: %s", $time, what);
		endtask

		// Compares one delivered result with the oldest outstanding one.
		task check_result(result_t got);
			result_t exp;

			if (pending_results.size() == 0) begin
				report_mismatch("result delivered with no request outstanding");
			end else begin
				exp = pending_results.pop_front();
				if (got.match !== exp.match)
					report_mismatch($sformatf("match: got %0b, expected %0b",
						got.match, exp.match));
				if (got.match_position !== exp.match_position)
					report_mismatch($sformatf("match_position: got %0d, expected %0d",
						got.match_position, exp.match_position));
				if (got.none_found !== exp.none_found)
					report_mismatch($sformatf("none_found: got %0b, expected %0b",
						got.none_found, exp.none_found));
				if (got.pattern_overflow !== exp.pattern_overflow)
					report_mismatch($sformatf("pattern_overflow: got %0b, expected %0b",
						got.pattern_overflow, exp.pattern_overflow));
				if (got.position_overflow !== exp.position_overflow)
					report_mismatch($sformatf("position_overflow: got %0b, expected %0b",
						got.position_overflow, exp.position_overflow));
			end
		endtask
	endclass

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	int offer_gap_pct = 0;
	int accept_stall_pct = 0;
	bit hold_request = 1'b0;
	logic [7:0] alpha_base = 8'h61;
	int alpha_span = 2;

	kmp_result_tracker tracker = new();

	kmp_stream_matcher uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Both handshakes are observed at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				tracker.note_request(item);
			if (result_valid && result_ready)
				tracker.check_result(result);
		end
	end

	// The receiver stalls at random, or holds off for a long stretch on demand.
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				result_ready <= ($urandom_range(0, 99) >= accept_stall_pct);
			end
		end
	end

	// The run is abandoned once nothing has moved for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [7:0] pick_char();
		if (alpha_span >= 256)
			return 8'($urandom_range(0, 255));
		return alpha_base + 8'($urandom_range(0, alpha_span - 1));
	endfunction

	// Offers one request, after an optional random gap, and waits for it to go in.
	task automatic send_request(input logic kind, input logic [7:0] c,
			input logic first, input logic last);
		item_t req;

		req.kind = kind;
		req.data_byte = c;
		req.first = first;
		req.last = last;
		while ($urandom_range(0, 99) < offer_gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Mostly well-formed patterns and texts over a narrow alphabet, with some noise.
	task automatic run_random(input int count);
		int sent;
		int pick;
		int len;
		bit start_new;
		bit close;

		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				if ($urandom_range(0, 2) == 0) begin
					alpha_base = 8'($urandom_range(0, 255));
					alpha_span = ($urandom_range(0, 5) == 0) ? 256 : $urandom_range(2, 3);
				end
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
				for (int i = 0; i < len; i++)
					send_request(KIND_PATTERN, pick_char(), i == 0, 1'($urandom_range(0, 1)));
				sent += len;
			end else if (pick < 22) begin
				send_request(KIND_PATTERN, pick_char(), 1'b0, 1'($urandom_range(0, 1)));
				sent++;
			end else if (pick < 92) begin
				len = $urandom_range(1, 24);
				start_new = ($urandom_range(0, 9) < 7);
				close = ($urandom_range(0, 9) < 6);
				for (int i = 0; i < len; i++)
					send_request(KIND_TEXT, pick_char(), start_new && i == 0,
						close && i == len - 1);
				sent += len;
			end else begin
				send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A text byte before any pattern is loaded matches nothing.
		send_request(KIND_TEXT, 8'h61, 1'b1, 1'b1);

		// Pattern of extreme characters; last on a pattern request has no effect.
		send_request(KIND_PATTERN, 8'hFF, 1'b1, 1'b1);
		send_request(KIND_PATTERN, 8'h00, 1'b0, 1'b0);
		send_request(KIND_PATTERN, 8'hFF, 1'b0, 1'b0);

		// Overlapping occurrences, then text that carries on without first.
		send_request(KIND_TEXT, 8'hFF, 1'b1, 1'b0);
		send_request(KIND_TEXT, 8'h00, 1'b0, 1'b0);
		send_request(KIND_TEXT, 8'hFF, 1'b0, 1'b0);
		send_request(KIND_TEXT, 8'h00, 1'b0, 1'b0);
		send_request(KIND_TEXT, 8'hFF, 1'b0, 1'b1);
		send_request(KIND_TEXT, 8'h00, 1'b0, 1'b0);
		send_request(KIND_TEXT, 8'hFF, 1'b0, 1'b0);

		// Extending the pattern mid-text keeps the partial match.
		send_request(KIND_PATTERN, 8'h00, 1'b0, 1'b0);
		send_request(KIND_TEXT, 8'h00, 1'b0, 1'b0);

		// A new pattern keeps the text index; then a fresh text with no occurrence.
		send_request(KIND_PATTERN, 8'h41, 1'b1, 1'b0);
		send_request(KIND_TEXT, 8'h41, 1'b0, 1'b0);
		send_request(KIND_TEXT, 8'h42, 1'b1, 1'b1);

		// Fill the pattern store to capacity; the extra bytes are dropped.
		for (int i = 0; i < 127; i++)
			send_request(KIND_PATTERN, 8'h61, i == 0, 1'b0);
		send_request(KIND_PATTERN, 8'h62, 1'b0, 1'b0);
		send_request(KIND_PATTERN, 8'h63, 1'b0, 1'b0);
		send_request(KIND_PATTERN, 8'h64, 1'b0, 1'b1);

		// Long failure walks against the full pattern.
		for (int i = 0; i < 130; i++)
			send_request(KIND_TEXT, 8'h61, i == 0, 1'b0);
		send_request(KIND_TEXT, 8'h62, 1'b0, 1'b0);
		send_request(KIND_TEXT, 8'h78, 1'b0, 1'b0);
		for (int i = 0; i < 127; i++)
			send_request(KIND_TEXT, 8'h61, 1'b0, 1'b0);
		send_request(KIND_TEXT, 8'h62, 1'b0, 1'b1);

		// A two-letter text against a short pattern.
		send_request(KIND_PATTERN, 8'h61, 1'b1, 1'b0);
		send_request(KIND_PATTERN, 8'h62, 1'b0, 1'b0);
		for (int i = 0; i < TEXT_RUN; i++)
			send_request(KIND_TEXT, 8'h61 + 8'($urandom_range(0, 1)), i == 0,
				i == TEXT_RUN - 1);
		send_request(KIND_PATTERN, 8'h61, 1'b0, 1'b0);
		send_request(KIND_TEXT, 8'h61, 1'b1, 1'b1);

		// Random traffic under each idling mix.
		run_random(100);
		offer_gap_pct = 48;
		run_random(100);
		offer_gap_pct = 0;
		accept_stall_pct = 48;
		run_random(100);
		offer_gap_pct = 20;
		accept_stall_pct = 20;
		run_random(100);

		// The receiver holds off while requests keep coming, so the block backs up.
		offer_gap_pct = 0;
		accept_stall_pct = 0;
		hold_request = 1'b1;
		run_random(100);

		item_valid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/kmp_pkg.sv
sv/kmp_store.sv
sv/kmp_walk.sv
sv/kmp_stream_matcher.sv
test/kmp_stream_matcher_test.sv
